// File: sv/ipid_pkg.sv
// Shared types and constants for the incremental PID wheel speed block.
// Holds the command/status structs between controller and datapath and CSR codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ipid_pkg;

   localparam int WHEELS_DEFAULT = 4;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MODE   = 2'd0,
      REG_GAIN_P = 2'd1,
      REG_GAIN_I = 2'd2,
      REG_GAIN_D = 2'd3
   } csr_reg_type;

   // Datapath operations, one issued per cycle by the controller unless it waits for a request or the output register
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_RPM,
      OP_ERR,
      OP_DIFF,
      OP_DMUL,
      OP_DFIX,
      OP_TMUL,
      OP_QMUL,
      OP_QFIX,
      OP_SFIX,
      OP_PMUL,
      OP_IMUL,
      OP_DDMUL,
      OP_ACCD,
      OP_DONE
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic present;
      logic scaled;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// File: sv/ipid_req_if.sv
// Tick request channel: valid/ready with wheel, count difference and target speed.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface ipid_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         wheel;
   logic signed [15:0] count_delta;
   logic signed [15:0] target_rpm;

   modport source (output valid, output wheel, output count_delta, output target_rpm,
                   input ready);
   modport sink   (input valid, input wheel, input count_delta, input target_rpm,
                   output ready);
endinterface

`default_nettype wire

// File: sv/ipid_rsp_if.sv
// Drive response channel: valid/ready with wheel channel and accumulated drive.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface ipid_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         wheel_out;
   logic signed [31:0] drive;

   modport source (output valid, output wheel_out, output drive, input ready);
   modport sink   (input valid, input wheel_out, input drive, output ready);
endinterface

`default_nettype wire

// File: sv/ipid_ctrl.sv
// Sequencer for the PID step: walks the datapath through one tick's operations.
// Depends on ipid_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module ipid_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire ipid_pkg::status_type status,
   output ipid_pkg::cmd_type         cmd
);

   typedef enum logic [14:0] {
      ST_IDLE  = 15'b000000000000001,
      ST_RPM   = 15'b000000000000010,
      ST_ERR   = 15'b000000000000100,
      ST_DIFF  = 15'b000000000001000,
      ST_DMUL  = 15'b000000000010000,
      ST_DFIX  = 15'b000000000100000,
      ST_TMUL  = 15'b000000001000000,
      ST_QMUL  = 15'b000000010000000,
      ST_QFIX  = 15'b000000100000000,
      ST_SFIX  = 15'b000001000000000,
      ST_PMUL  = 15'b000010000000000,
      ST_IMUL  = 15'b000100000000000,
      ST_DDMUL = 15'b001000000000000,
      ST_ACCD  = 15'b010000000000000,
      ST_DONE  = 15'b100000000000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd.op    = ipid_pkg::OP_NONE;
      req_ready = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = ipid_pkg::OP_LOAD;
               state_in = ST_RPM;
            end
         end
         ST_RPM: begin
            cmd.op   = ipid_pkg::OP_RPM;
            // a channel that is not fitted skips straight to the result
            state_in = status.present ? ST_ERR : ST_DONE;
         end
         ST_ERR: begin
            cmd.op   = ipid_pkg::OP_ERR;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.op   = ipid_pkg::OP_DIFF;
            state_in = status.scaled ? ST_DMUL : ST_PMUL;
         end
         ST_DMUL: begin
            cmd.op   = ipid_pkg::OP_DMUL;
            state_in = ST_DFIX;
         end
         ST_DFIX: begin
            cmd.op   = ipid_pkg::OP_DFIX;
            state_in = ST_TMUL;
         end
         ST_TMUL: begin
            cmd.op   = ipid_pkg::OP_TMUL;
            state_in = ST_QMUL;
         end
         ST_QMUL: begin
            cmd.op   = ipid_pkg::OP_QMUL;
            state_in = ST_QFIX;
         end
         ST_QFIX: begin
            cmd.op   = ipid_pkg::OP_QFIX;
            state_in = ST_SFIX;
         end
         ST_SFIX: begin
            cmd.op   = ipid_pkg::OP_SFIX;
            state_in = ST_PMUL;
         end
         ST_PMUL: begin
            cmd.op   = ipid_pkg::OP_PMUL;
            state_in = ST_IMUL;
         end
         ST_IMUL: begin
            cmd.op   = ipid_pkg::OP_IMUL;
            state_in = ST_DDMUL;
         end
         ST_DDMUL: begin
            cmd.op   = ipid_pkg::OP_DDMUL;
            state_in = ST_ACCD;
         end
         ST_ACCD: begin
            cmd.op   = ipid_pkg::OP_ACCD;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register can take the beat
            if (status.out_free) begin
               cmd.op   = ipid_pkg::OP_DONE;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("controller state lost its one-hot code");

endmodule

`default_nettype wire

// File: sv/ipid_dp.sv
// Datapath for the PID step: per-wheel state, CSRs, shared multiplier, output register.
// Depends on ipid_pkg; driven one operation per cycle by ipid_ctrl while a tick runs and the output is free.
`timescale 1ns / 1ps
`default_nettype none

module ipid_dp #(
   parameter int WHEELS = ipid_pkg::WHEELS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire ipid_pkg::cmd_type                  cmd,
   output ipid_pkg::status_type                    status,
   input  wire logic [1:0]                         req_wheel,
   input  wire logic signed [15:0]                 req_count_delta,
   input  wire logic signed [15:0]                 req_target_rpm,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_valid,
   output logic [1:0]                              rsp_wheel_out,
   output logic signed [31:0]                      rsp_drive,
   input  wire logic                               csr_we,
   input  wire logic [ipid_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [ipid_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int IDX_W  = (WHEELS > 1) ? $clog2(WHEELS) : 1;
   localparam int MUL_W  = 21;
   localparam int PROD_W = 2 * MUL_W;

   // reciprocals: /5 exact for 16-bit magnitudes, /21 for small magnitudes,
   // /5000 within one of the quotient (fixed up afterwards)
   localparam logic signed [MUL_W-1:0] RECIP_5    = 21'sd52429;
   localparam logic signed [MUL_W-1:0] RECIP_21   = 21'sd3121;
   localparam logic signed [MUL_W-1:0] RECIP_5000 = 21'sd858993;
   localparam logic signed [MUL_W-1:0] MUL_5000   = 21'sd5000;
   localparam logic [19:0]             REM_5000   = 20'd5000;
   localparam logic [19:0]             REM_LIMIT  = 20'd10000;
   localparam logic [15:0]             D_SAT_MAG  = 16'd138;
   localparam logic signed [33:0]      DRIVE_HI   = 34'sd65534;
   localparam logic signed [33:0]      DRIVE_LO   = -34'sd2147483648;

   function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
      logic signed [15:0] r;
      if (v > 34'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -34'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // Q8.8 product back to integer, rounded toward zero
   function automatic logic signed [23:0] qterm(input logic signed [PROD_W-1:0] p);
      logic signed [31:0] p32;
      logic signed [31:0] adj;
      p32 = p[31:0];
      adj = p32 + (p32[31] ? 32'sd255 : 32'sd0);
      return adj[31:8];
   endfunction

   // configuration
   logic               mode_ff;
   logic signed [15:0] gain_p_ff;
   logic signed [15:0] gain_i_ff;
   logic signed [15:0] gain_d_ff;

   // per-wheel state
   logic signed [15:0] last_err_ff  [WHEELS];
   logic signed [15:0] err_sum_ff   [WHEELS];
   logic signed [31:0] drive_acc_ff [WHEELS];

   // working registers of the current tick
   logic [1:0]              wheel_ff;
   logic [IDX_W-1:0]        idx_ff;
   logic signed [15:0]      cnt_ff;
   logic signed [15:0]      tgt_ff;
   logic signed [15:0]      last_ff;
   logic signed [15:0]      esum_ff;
   logic signed [31:0]      accum_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [15:0]      e_ff;
   logic signed [16:0]      diff_ff;
   logic [19:0]             tmag_ff;
   logic signed [15:0]      d_ff;
   logic signed [15:0]      s_ff;
   logic [7:0]              q0_ff;
   logic [7:0]              q_ff;
   logic                    rnz_ff;
   logic signed [33:0]      acc_ff;

   // output register
   logic                    rsp_valid_ff;
   logic [1:0]              wheel_out_ff;
   logic signed [31:0]      drive_ff;

   logic                    req_present;
   logic [IDX_W-1:0]        rd_idx;
   logic                    present;
   logic                    out_free;

   logic signed [MUL_W-1:0]  mul_a;
   logic signed [MUL_W-1:0]  mul_b;
   logic signed [PROD_W-1:0] prod_in;

   logic [15:0]             cnt_abs;
   logic signed [23:0]      cnt_x82;
   logic signed [23:0]      q5;
   logic signed [23:0]      rpm;
   logic signed [15:0]      e_in;

   logic signed [16:0]      diff_in;
   logic [15:0]             e_abs;
   logic [19:0]             tmag_in;
   logic signed [15:0]      d_raw_in;
   logic signed [15:0]      s_raw_in;

   logic [15:0]             dmag;
   logic [15:0]             dx238;
   logic [15:0]             dsmall;
   logic                    dlarge;
   logic signed [15:0]      d_fix_in;

   logic [19:0]             rem0;
   logic [7:0]              q_in;
   logic                    rnz_in;

   logic signed [17:0]      qs;
   logic signed [17:0]      n_sum;
   logic signed [17:0]      n_adj;
   logic signed [15:0]      s_fix_in;

   logic signed [23:0]      term_in;
   logic signed [33:0]      acc_base;
   logic signed [33:0]      acc_in;
   logic signed [31:0]      drive_in;

   assign req_present = (32'(req_wheel) < WHEELS);
   assign rd_idx      = req_present ? IDX_W'(req_wheel) : '0;
   assign present     = (32'(wheel_ff) < WHEELS);
   assign out_free    = !rsp_valid_ff || rsp_ready;

   assign status.present  = present;
   assign status.scaled   = mode_ff;
   assign status.out_free = out_free;

   // ---- speed and error ----
   assign cnt_abs = cnt_ff[15] ? 16'(-cnt_ff) : 16'(cnt_ff);
   // 82.2 * cnt = 82 * cnt + cnt / 5, both parts of one sign
   assign cnt_x82 = (24'(cnt_ff) <<< 6) + (24'(cnt_ff) <<< 4) + (24'(cnt_ff) <<< 1);
   assign q5      = $signed({11'b0, prod_ff[30:18]});
   assign rpm     = cnt_x82 + (cnt_ff[15] ? -q5 : q5);
   assign e_in    = sat16(34'(tgt_ff) - 34'(rpm));

   // ---- raw difference and sum ----
   assign diff_in  = 17'(e_ff) - 17'(last_ff);
   assign e_abs    = e_ff[15] ? 16'(-e_ff) : 16'(e_ff);
   assign tmag_in  = ({4'b0, e_abs} << 4) + ({4'b0, e_abs} << 2) + {4'b0, e_abs};
   assign d_raw_in = sat16(34'(diff_in));
   assign s_raw_in = sat16(34'(esum_ff) + 34'(e_ff));

   // ---- scaled derivative: diff * 5000 / 21 = 238 * diff + 2 * diff / 21 ----
   assign dmag   = diff_ff[16] ? 16'(-diff_ff) : 16'(diff_ff);
   assign dlarge = (dmag >= D_SAT_MAG);
   assign dx238  = ({8'b0, dmag[7:0]} << 8) - ({8'b0, dmag[7:0]} << 4)
                 - ({8'b0, dmag[7:0]} << 1);
   assign dsmall = dx238 + {12'b0, prod_ff[19:16]};

   always_comb begin
      if (diff_ff[16]) begin
         d_fix_in = dlarge ? 16'sh8000 : 16'(-$signed(dsmall));
      end else begin
         d_fix_in = dlarge ? 16'sh7fff : $signed(dsmall);
      end
   end

   // ---- scaled integral step: quotient and remainder of 21 * |e| / 5000 ----
   assign rem0   = tmag_ff - prod_ff[19:0];
   assign q_in   = (rem0 >= REM_5000) ? (q0_ff + 8'd1) : q0_ff;
   assign rnz_in = (rem0 != 20'd0) && (rem0 != REM_5000);

   assign qs    = e_ff[15] ? -$signed({10'b0, q_ff}) : $signed({10'b0, q_ff});
   assign n_sum = 18'(esum_ff) + qs;

   // a leftover fraction against the sign of the sum pulls it toward zero
   always_comb begin
      n_adj = n_sum;
      if (rnz_ff && (n_sum > 18'sd0) && e_ff[15]) begin
         n_adj = n_sum - 18'sd1;
      end else if (rnz_ff && (n_sum < 18'sd0) && !e_ff[15]) begin
         n_adj = n_sum + 18'sd1;
      end
   end

   assign s_fix_in = sat16(34'(n_adj));

   // ---- drive accumulation ----
   assign term_in  = qterm(prod_ff);
   assign acc_base = (cmd.op == ipid_pkg::OP_IMUL) ? 34'(accum_ff) : acc_ff;
   assign acc_in   = acc_base + 34'(term_in);

   always_comb begin
      if (acc_ff > DRIVE_HI) begin
         drive_in = 32'(DRIVE_HI);
      end else if (acc_ff < DRIVE_LO) begin
         drive_in = 32'(DRIVE_LO);
      end else begin
         drive_in = acc_ff[31:0];
      end
   end

   // ---- shared multiplier ----
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         ipid_pkg::OP_RPM: begin
            mul_a = $signed({5'b0, cnt_abs});
            mul_b = RECIP_5;
         end
         ipid_pkg::OP_DMUL: begin
            mul_a = $signed({12'b0, dmag[7:0], 1'b0});
            mul_b = RECIP_21;
         end
         ipid_pkg::OP_TMUL: begin
            mul_a = $signed({1'b0, tmag_ff});
            mul_b = RECIP_5000;
         end
         ipid_pkg::OP_QMUL: begin
            mul_a = $signed({13'b0, prod_ff[39:32]});
            mul_b = MUL_5000;
         end
         ipid_pkg::OP_PMUL: begin
            mul_a = MUL_W'(gain_p_ff);
            mul_b = MUL_W'(e_ff);
         end
         ipid_pkg::OP_IMUL: begin
            mul_a = MUL_W'(gain_i_ff);
            mul_b = MUL_W'(s_ff);
         end
         ipid_pkg::OP_DDMUL: begin
            mul_a = MUL_W'(gain_d_ff);
            mul_b = MUL_W'(d_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // ---- control state: CSRs, per-wheel state, output valid ----
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         gain_p_ff    <= '0;
         gain_i_ff    <= '0;
         gain_d_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < WHEELS; k++) begin
            last_err_ff[k]  <= '0;
            err_sum_ff[k]   <= '0;
            drive_acc_ff[k] <= '0;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               ipid_pkg::REG_MODE:   mode_ff   <= csr_wdata[0];
               ipid_pkg::REG_GAIN_P: gain_p_ff <= $signed(csr_wdata);
               ipid_pkg::REG_GAIN_I: gain_i_ff <= $signed(csr_wdata);
               ipid_pkg::REG_GAIN_D: gain_d_ff <= $signed(csr_wdata);
               default: begin
               end
            endcase
         end
         if (cmd.op == ipid_pkg::OP_DONE) begin
            rsp_valid_ff <= 1'b1;
            if (present) begin
               last_err_ff[idx_ff]  <= e_ff;
               err_sum_ff[idx_ff]   <= s_ff;
               drive_acc_ff[idx_ff] <= drive_in;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---- payload registers ----
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      unique case (cmd.op)
         ipid_pkg::OP_LOAD: begin
            wheel_ff <= req_wheel;
            idx_ff   <= rd_idx;
            cnt_ff   <= req_count_delta;
            tgt_ff   <= req_target_rpm;
            last_ff  <= last_err_ff[rd_idx];
            esum_ff  <= err_sum_ff[rd_idx];
            accum_ff <= drive_acc_ff[rd_idx];
         end
         ipid_pkg::OP_ERR: begin
            e_ff <= e_in;
         end
         ipid_pkg::OP_DIFF: begin
            diff_ff <= diff_in;
            tmag_ff <= tmag_in;
            d_ff    <= d_raw_in;
            s_ff    <= s_raw_in;
         end
         ipid_pkg::OP_DFIX: begin
            d_ff <= d_fix_in;
         end
         ipid_pkg::OP_QMUL: begin
            q0_ff <= prod_ff[39:32];
         end
         ipid_pkg::OP_QFIX: begin
            q_ff   <= q_in;
            rnz_ff <= rnz_in;
         end
         ipid_pkg::OP_SFIX: begin
            s_ff <= s_fix_in;
         end
         ipid_pkg::OP_IMUL, ipid_pkg::OP_DDMUL, ipid_pkg::OP_ACCD: begin
            acc_ff <= acc_in;
         end
         ipid_pkg::OP_DONE: begin
            wheel_out_ff <= wheel_ff;
            drive_ff     <= present ? drive_in : 32'sd0;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_wheel_out = wheel_out_ff;
   assign rsp_drive     = drive_ff;

   a_drive_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (drive_ff <= 32'sd65534))
      else $error("drive beat above the upper clamp");

   a_absent_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !(32'(wheel_out_ff) < WHEELS)) |-> (drive_ff == 32'sd0))
      else $error("drive beat for an absent wheel is not zero");

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == ipid_pkg::OP_QFIX) |-> (rem0 < REM_LIMIT))
      else $error("quotient estimate for the integral step off by more than one");

   a_done_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == ipid_pkg::OP_DONE) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result written over an untaken beat");

endmodule

`default_nettype wire

// File: sv/incremental_pid_wheel_speed.sv
// Incremental PID speed loop for up to WHEELS wheel channels, one shared multiplier.
// Each tick is stepped by the sequencer through the single multiplier, with extra steps in
// time-scaled mode and a shortcut for an absent wheel; a new tick is taken only once the
// last result is in the output register, and a result may wait while the next is taken.
// Synchronous reset clears the sequencer, CSRs and all per-wheel state at once.
`timescale 1ns / 1ps
`default_nettype none

module incremental_pid_wheel_speed #(
   parameter int WHEELS = ipid_pkg::WHEELS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   ipid_req_if.sink                             req_bus,
   ipid_rsp_if.source                           rsp_bus,
   input  wire logic                            csr_we,
   input  wire logic [ipid_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ipid_pkg::CSR_DATA_W-1:0] csr_wdata
);

   ipid_pkg::cmd_type    cmd;
   ipid_pkg::status_type status;
   logic                 req_ready;

   assign req_bus.ready = req_ready;

   ipid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ipid_dp #(
      .WHEELS (WHEELS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_wheel       (req_bus.wheel),
      .req_count_delta (req_bus.count_delta),
      .req_target_rpm  (req_bus.target_rpm),
      .rsp_ready       (rsp_bus.ready),
      .rsp_valid       (rsp_bus.valid),
      .rsp_wheel_out   (rsp_bus.wheel_out),
      .rsp_drive       (rsp_bus.drive),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

endmodule

`default_nettype wire

// File: verif/tb_incremental_pid_wheel_speed.sv
// Self-checking bench for incremental_pid_wheel_speed: drives tick beats, predicts each
// wheel's drive in its own model of the PID loop and checks every result beat in order.
// Depends on ipid_pkg and the ipid_req_if / ipid_rsp_if interfaces.
`timescale 1ns / 1ps

module tb_incremental_pid_wheel_speed;

   localparam int     WHEELS            = ipid_pkg::WHEELS_DEFAULT;
   localparam int     QUIET_LIMIT       = 4000;
   localparam int     LONG_STALL_CYCLES = 400;
   localparam int     SETTLE_CYCLES     = 20;
   localparam longint DRIVE_CEIL        = 65534;
   localparam longint DRIVE_FLOOR       = -64'sd2147483648;

   typedef struct packed {
      logic [1:0]         wheel;
      logic signed [15:0] count_delta;
      logic signed [15:0] target_rpm;
   } tick_type;

   typedef struct packed {
      logic [1:0]         wheel;
      logic signed [31:0] drive;
   } drive_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                            csr_we;
   logic [ipid_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [ipid_pkg::CSR_DATA_W-1:0] csr_wdata;

   ipid_req_if req_bus ();
   ipid_rsp_if rsp_bus ();

   incremental_pid_wheel_speed #(.WHEELS(WHEELS)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   tick_type         pending_ticks[$];
   drive_result_type expected_drives[$];

   // Per-wheel loop state and register copies of the predictor
   logic signed [15:0] last_err_q[WHEELS];
   logic signed [15:0] err_sum_q[WHEELS];
   logic signed [31:0] drive_acc_q[WHEELS];
   logic               cfg_scaled;
   logic signed [15:0] cfg_gain_p, cfg_gain_i, cfg_gain_d;

   int send_idle_pct, recv_idle_pct;
   int mismatch_count, ticks_accepted, results_seen, settings_applied;
   bit long_stall_armed;
   int long_stall_at, long_stall_left, quiet_cycles;

   function automatic logic signed [15:0] clip16(longint v);
      if (v > 32767) return 16'h7fff;
      if (v < -32768) return 16'h8000;
      return v[15:0];
   endfunction

   function automatic longint gain_term(logic signed [15:0] gain, logic signed [15:0] x);
      return (longint'(gain) * longint'(x)) / 256;
   endfunction

   function automatic drive_result_type step_wheel_loop(tick_type t);
      drive_result_type   r;
      longint             rpm, acc;
      logic signed [15:0] e16, d16, s16;
      int                 ch;
      ch = int'(t.wheel);
      r.wheel = t.wheel;
      if (ch >= WHEELS) begin
         r.drive = '0;
         return r;
      end
      rpm = (longint'($signed(t.count_delta)) * 822) / 10;
      e16 = clip16(longint'($signed(t.target_rpm)) - rpm);
      if (cfg_scaled) begin
         d16 = clip16(((longint'(e16) - longint'(last_err_q[ch])) * 5000) / 21);
         s16 = clip16((longint'(err_sum_q[ch]) * 5000 + longint'(e16) * 21) / 5000);
      end else begin
         d16 = clip16(longint'(e16) - longint'(last_err_q[ch]));
         s16 = clip16(longint'(err_sum_q[ch]) + longint'(e16));
      end
      acc = longint'(drive_acc_q[ch]) + gain_term(cfg_gain_p, e16)
          + gain_term(cfg_gain_d, d16) + gain_term(cfg_gain_i, s16);
      if (acc > DRIVE_CEIL) acc = DRIVE_CEIL;
      if (acc < DRIVE_FLOOR) acc = DRIVE_FLOOR;
      last_err_q[ch]  = e16;
      err_sum_q[ch]   = s16;
      drive_acc_q[ch] = acc[31:0];
      r.drive = acc[31:0];
      return r;
   endfunction

   task automatic flag_mismatch(string what, longint want, longint got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("[%0t] mismatch: %s expected %0d got %0d", $realtime, what, want, got);
   endtask

   // Driver: present the next pending tick when the channel is free
   always @(posedge clock) begin : tick_driver
      tick_type seen, nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            seen.wheel       = req_bus.wheel;
            seen.count_delta = req_bus.count_delta;
            seen.target_rpm  = req_bus.target_rpm;
            expected_drives.push_back(step_wheel_loop(seen));
            ticks_accepted++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_ticks.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_ticks.pop_front();
               req_bus.valid       <= 1'b1;
               req_bus.wheel       <= nxt.wheel;
               req_bus.count_delta <= nxt.count_delta;
               req_bus.target_rpm  <= nxt.target_rpm;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each result beat against the oldest prediction
   always @(posedge clock) begin : drive_monitor
      drive_result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (expected_drives.size() == 0) begin
               flag_mismatch("drive with no tick pending", 0, longint'(rsp_bus.drive));
            end else begin
               want = expected_drives.pop_front();
               if (rsp_bus.wheel_out !== want.wheel)
                  flag_mismatch("wheel_out", longint'(want.wheel),
                                longint'(rsp_bus.wheel_out));
               if (rsp_bus.drive !== want.drive)
                  flag_mismatch("drive", longint'(want.drive), longint'(rsp_bus.drive));
            end
         end
         if (long_stall_left > 0) begin
            long_stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (long_stall_armed && results_seen >= long_stall_at) begin
            // hold off long enough for the block to back up into the tick channel
            long_stall_armed = 1'b0;
            long_stall_left  = LONG_STALL_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] no beat for %0d cycles", $realtime, QUIET_LIMIT);
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   function automatic logic [15:0] edge_value16();
      case ($urandom_range(4))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         2:       return 16'h0000;
         3:       return 16'hffff;
         default: return 16'h0001;
      endcase
   endfunction

   function automatic logic [15:0] span16(int span);
      return 16'(int'($urandom_range(0, 2 * span)) - span);
   endfunction

   function automatic tick_type make_tick(bit drive_down);
      tick_type t;
      int       pick;
      pick = $urandom_range(99);
      if (drive_down && pick < 65) begin
         // pin wheel 0 at the most negative error to walk its drive to the floor
         t.wheel       = 2'd0;
         t.count_delta = 16'h7fff;
         t.target_rpm  = 16'h8000;
         return t;
      end
      t.wheel = 2'($urandom_range(3));
      pick = $urandom_range(99);
      if (pick < 12) begin
         t.count_delta = edge_value16();
         t.target_rpm  = edge_value16();
      end else if (pick < 45) begin
         // target close to the measured speed keeps the error small
         t.count_delta = span16(300);
         t.target_rpm  = 16'(int'($signed(t.count_delta)) * 82 + int'($signed(span16(60))));
      end else if (pick < 75) begin
         t.count_delta = span16(300);
         t.target_rpm  = span16(25000);
      end else begin
         t.count_delta = 16'($urandom);
         t.target_rpm  = 16'($urandom);
      end
      return t;
   endfunction

   task automatic queue_tick(int w, int cnt, int tgt);
      tick_type t;
      t.wheel       = w[1:0];
      t.count_delta = cnt[15:0];
      t.target_rpm  = tgt[15:0];
      pending_ticks.push_back(t);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pending_ticks.size() != 0 || req_bus.valid || expected_drives.size() != 0)
         @(negedge clock);
   endtask

   // Write all four registers on back-to-back edges; call only while drained
   task automatic apply_settings(logic mode, logic [15:0] gp, logic [15:0] gi,
                                 logic [15:0] gd);
      logic [15:0]                    junk, value;
      logic [ipid_pkg::CSR_IDX_W-1:0] idx;
      junk = 16'($urandom);
      for (int k = 0; k < 4; k++) begin
         idx = k[ipid_pkg::CSR_IDX_W-1:0];
         case (idx)
            ipid_pkg::REG_MODE:   value = {junk[14:0], mode};
            ipid_pkg::REG_GAIN_P: value = gp;
            ipid_pkg::REG_GAIN_I: value = gi;
            default:              value = gd;
         endcase
         @(posedge clock);
         csr_we    <= 1'b1;
         csr_index <= idx;
         csr_wdata <= value;
         case (idx)
            ipid_pkg::REG_MODE:   cfg_scaled = value[0];
            ipid_pkg::REG_GAIN_P: cfg_gain_p = value;
            ipid_pkg::REG_GAIN_I: cfg_gain_i = value;
            default:              cfg_gain_d = value;
         endcase
      end
      @(posedge clock);
      csr_we <= 1'b0;
      settings_applied++;
   endtask

   task automatic run_batch(int n, bit drive_down);
      @(negedge clock);
      repeat (n) pending_ticks.push_back(make_tick(drive_down));
      wait_drained();
   endtask

   initial begin
      req_bus.valid       = 1'b0;
      req_bus.wheel       = '0;
      req_bus.count_delta = '0;
      req_bus.target_rpm  = '0;
      rsp_bus.ready       = 1'b0;
      csr_we              = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      for (int k = 0; k < WHEELS; k++) begin
         last_err_q[k]  = '0;
         err_sum_q[k]   = '0;
         drive_acc_q[k] = '0;
      end
      cfg_scaled       = 1'b0;
      cfg_gain_p       = '0;
      cfg_gain_i       = '0;
      cfg_gain_d       = '0;
      send_idle_pct    = 31;
      recv_idle_pct    = 51;
      long_stall_armed = 1'b0;
      long_stall_left  = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed, raw mode: field extremes, error saturation both ways, zero error
      apply_settings(1'b0, 16'd256, 16'd32, -16'sd128);
      @(negedge clock);
      queue_tick(0, 0, 0);
      queue_tick(1, 32767, 32767);
      queue_tick(2, -32768, -32768);
      queue_tick(3, 0, 32767);
      queue_tick(0, -32768, 32767);
      queue_tick(1, 32767, -32768);
      queue_tick(2, 1, 0);
      queue_tick(3, -1, 0);
      queue_tick(0, 10, 822);
      queue_tick(1, -10, -1000);
      wait_drained();

      // Directed, time-scaled mode at extreme gains: upper drive clamp, scaled saturation
      apply_settings(1'b1, 16'h7fff, 16'h8000, 16'h7fff);
      @(negedge clock);
      queue_tick(0, -32768, 32767);
      queue_tick(0, -32768, 32767);
      queue_tick(1, 3, 0);
      queue_tick(2, 0, 100);
      queue_tick(2, 0, -100);
      queue_tick(3, 32767, -32768);
      queue_tick(1, -1, 1);
      queue_tick(2, 5, -5);
      queue_tick(3, 0, 0);
      queue_tick(0, 0, 0);
      wait_drained();

      // Raw mode, random gains; the drain in the middle pauses the sender
      apply_settings(1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
      run_batch(200, 1'b0);
      run_batch(250, 1'b0);

      @(negedge clock);
      send_idle_pct = 51;
      recv_idle_pct = 31;
      apply_settings(1'b1, span16(2048), span16(2048), span16(64));
      run_batch(450, 1'b0);

      @(negedge clock);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      apply_settings(1'b0, 16'h7fff, 16'h7fff, 16'h7fff);
      run_batch(450, 1'b1);

      apply_settings(1'b1, 16'h8000, span16(512), 16'h8000);
      @(negedge clock);
      long_stall_at    = results_seen + 50;
      long_stall_armed = 1'b1;
      run_batch(350, 1'b0);

      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      if (expected_drives.size() != 0)
         flag_mismatch("drives never delivered", 0, longint'(expected_drives.size()));

      $display("Checked %0d drive beats from %0d tick beats over %0d register settings.",
               results_seen, ticks_accepted, settings_applied);
      $display("Both modes, extreme gains, drive clamp and floor; %0d mismatches.",
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
